>>> design/cdg_pkg.sv
package cdg_pkg;

	// Field widths
	localparam int SAMPLE_W   = 8;
	localparam int DIFF_W     = 9;
	localparam int BYTE_W     = 7;
	localparam int ROW_W      = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_DATA_W = 2 * DIFF_W + 2 * BYTE_W;

	// Frame limits and reset geometry
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int WIDTH_RST     = 1024;
	localparam int HEIGHT_RST    = 768;

	// Item kinds carried on s_tuser
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// Per-beat command from the sequencer to the gradient stage
	typedef struct packed {
		logic rd;         // beat consumed, line buffers read
		logic emit;       // beat produces a result
		logic first_row;  // emitted row is row 0: above is the center
		logic last_col;   // rightmost column: right is the center
		logic col_zero;   // leftmost column: left is the center
		logic drain;      // drain beat: below is the center
		logic frame_end;  // final result of the frame
	} cdg_cmd_t;

endpackage

>>> design/central_difference_gradient.sv
// Streaming central-difference gradient over an 8-bit grey frame in raster order.
// Send pixel beats (s_tuser 0) for the whole frame, then one drain beat
// (s_tuser 1) per column to flush the last row; results for row r come out
// while row r+1 streams in, and m_tlast marks the final result of the frame.
// The block takes one beat per clock while the output is not held. A result
// passes through the stage 1 register and then the output register. The rate is set by the
// two line buffers (the row being emitted and the row above it), each a
// single-read, single-write RAM with a registered read port: every beat
// does one read and at most one write per buffer. The line buffers need no
// clearing pass after reset. Configuration writes restart the frame.
module central_difference_gradient #(
	parameter int MAX_WIDTH = cdg_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cdg_pkg::SAMPLE_W-1:0]       s_tdata,   // [7:0] sample
	input  logic                               s_tuser,   // [0] func
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cdg_pkg::OUT_DATA_W-1:0]     m_tdata,   // [8:0] grad_x_diff, [17:9] grad_y_diff,
	                                                      // [24:18] red_byte, [31:25] green_byte
	output logic                               m_tlast,   // frame_end
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [cdg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	cdg_pkg::cdg_cmd_t             cmd;
	cdg_pkg::cfg_idx_t             cfg_idx;
	logic                          in_fire;
	logic                          cfg_fire;
	logic                          mid_wr_en;
	logic [AW-1:0]                 col_addr;
	logic [AW-1:0]                 mid_rd_addr;
	logic [cdg_pkg::SAMPLE_W-1:0]  mid_rdata;
	logic [cdg_pkg::SAMPLE_W-1:0]  mid_rd_raw;
	logic [cdg_pkg::SAMPLE_W-1:0]  upper_rdata;
	logic                          mid_fwd_q;
	logic [cdg_pkg::SAMPLE_W-1:0]  mid_fwd_data_q;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_idx   = cdg_pkg::cfg_idx_t'(cfg_index);

	cdg_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_fire    (cfg_fire),
		.cfg_index   (cfg_idx),
		.cfg_data    (cfg_data),
		.in_fire     (in_fire),
		.func        (s_tuser),
		.cmd         (cmd),
		.mid_wr_en   (mid_wr_en),
		.col_addr    (col_addr),
		.mid_rd_addr (mid_rd_addr)
	);

	// Row being emitted: take the new pixel, fetch the right neighbor
	cdg_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_mid_mem (
		.clk     (clk),
		.wr_en   (mid_wr_en),
		.wr_addr (col_addr),
		.wr_data (s_tdata),
		.rd_en   (cmd.rd),
		.rd_addr (mid_rd_addr),
		.rd_data (mid_rd_raw)
	);

	// Forward the pixel written at the address being read: a one-column row
	// reads back the very entry it overwrites in the same beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_fwd_q <= 1'b0;
		end else if (cmd.rd) begin
			mid_fwd_q <= mid_wr_en && (mid_rd_addr == col_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			mid_fwd_data_q <= s_tdata;
		end
	end

	assign mid_rdata = mid_fwd_q ? mid_fwd_data_q : mid_rd_raw;

	// Row above: read the old entry, retire the current center into it
	cdg_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_upper_mem (
		.clk     (clk),
		.wr_en   (cmd.emit),
		.wr_addr (col_addr),
		.wr_data (mid_rdata),
		.rd_en   (cmd.rd),
		.rd_addr (col_addr),
		.rd_data (upper_rdata)
	);

	cdg_grad u_grad (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample      (s_tdata),
		.mid_rdata   (mid_rdata),
		.upper_rdata (upper_rdata),
		.in_ready    (s_tready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

>>> design/cdg_line_mem.sv
module cdg_line_mem #(
	parameter int DEPTH = cdg_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [cdg_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [cdg_pkg::SAMPLE_W-1:0]  rd_data
);

	logic [cdg_pkg::SAMPLE_W-1:0] mem [DEPTH];

	// Read-first: a read at the written address returns the old entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/cdg_ctrl.sv
module cdg_ctrl #(
	parameter int MAX_WIDTH = cdg_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_fire,
	input  cdg_pkg::cfg_idx_t               cfg_index,
	input  logic [cdg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_fire,
	input  logic                            func,
	output cdg_pkg::cdg_cmd_t               cmd,
	output logic                            mid_wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]    col_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]    mid_rd_addr
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int W_RST = (cdg_pkg::WIDTH_RST < MAX_WIDTH) ? cdg_pkg::WIDTH_RST : MAX_WIDTH;
	localparam logic [AW-1:0] WM1_RST = AW'(W_RST - 1);
	localparam logic [cdg_pkg::ROW_W-1:0] HM1_RST = cdg_pkg::ROW_W'(cdg_pkg::HEIGHT_RST - 1);
	localparam logic [cdg_pkg::ROW_W-1:0] HM1_MAX = cdg_pkg::ROW_W'(cdg_pkg::MAX_HEIGHT - 1);

	logic [AW-1:0]               wm1_q;
	logic [cdg_pkg::ROW_W-1:0]   hm1_q;
	logic [AW-1:0]               col_q;
	logic [cdg_pkg::ROW_W-1:0]   row_q;
	logic                        drain_q;

	logic [cdg_pkg::FW_W-1:0]    fw;
	logic [cdg_pkg::FH_W-1:0]    fh;
	logic [AW-1:0]               wm1_new;
	logic [cdg_pkg::ROW_W-1:0]   hm1_new;
	logic                        take_pixel;
	logic                        take_drain;
	logic                        last;

	// Clamp written geometry into range and keep it as last index
	always_comb begin
		fw = cfg_data[cdg_pkg::FW_W-1:0];
		fh = cfg_data[cdg_pkg::FH_W-1:0];
		if (fw == '0) begin
			wm1_new = '0;
		end else if (32'(fw) > MAX_WIDTH) begin
			wm1_new = AW'(MAX_WIDTH - 1);
		end else begin
			wm1_new = AW'(fw - cdg_pkg::FW_W'(1));
		end
		if (fh == '0) begin
			hm1_new = '0;
		end else if (32'(fh) > cdg_pkg::MAX_HEIGHT) begin
			hm1_new = HM1_MAX;
		end else begin
			hm1_new = cdg_pkg::ROW_W'(fh - cdg_pkg::FH_W'(1));
		end
	end

	// Decode the beat against the frame position
	always_comb begin
		take_pixel = in_fire && (func == cdg_pkg::FUNC_PIXEL) && !drain_q;
		take_drain = in_fire && (func == cdg_pkg::FUNC_DRAIN) && drain_q;
		last       = (col_q == wm1_q);

		cmd.rd        = take_pixel || take_drain;
		cmd.emit      = take_drain || (take_pixel && (row_q != '0));
		cmd.first_row = drain_q ? (row_q == '0) : (row_q == cdg_pkg::ROW_W'(1));
		cmd.last_col  = last;
		cmd.col_zero  = (col_q == '0);
		cmd.drain     = drain_q;
		cmd.frame_end = drain_q && last;

		mid_wr_en   = take_pixel;
		col_addr    = col_q;
		// Fetch the right neighbor; at row end prefetch column 0 for the next row
		mid_rd_addr = last ? '0 : col_q + AW'(1);
	end

	// Geometry registers and frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q   <= WM1_RST;
			hm1_q   <= HM1_RST;
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				cdg_pkg::CFG_FRAME_WIDTH:  wm1_q <= wm1_new;
				cdg_pkg::CFG_FRAME_HEIGHT: hm1_q <= hm1_new;
				default:                   wm1_q <= wm1_q;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
		end else if (take_pixel) begin
			if (last) begin
				col_q <= '0;
				if (row_q == hm1_q) begin
					drain_q <= 1'b1;
				end else begin
					row_q <= row_q + cdg_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + AW'(1);
			end
		end else if (take_drain) begin
			if (last) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= 1'b0;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// Column never runs past the row end
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wm1_q)
		else $error("column counter past row end");

	// Drain only ever runs on the last row
	a_drain_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (row_q == hm1_q))
		else $error("draining outside the last row");

endmodule

>>> design/cdg_grad.sv
module cdg_grad (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cdg_pkg::cdg_cmd_t                  cmd,
	input  logic [cdg_pkg::SAMPLE_W-1:0]       sample,
	input  logic [cdg_pkg::SAMPLE_W-1:0]       mid_rdata,
	input  logic [cdg_pkg::SAMPLE_W-1:0]       upper_rdata,
	output logic                               in_ready,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cdg_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                               out_last
);

	logic                               v_s1;
	logic [cdg_pkg::SAMPLE_W-1:0]       center_s1;
	logic [cdg_pkg::SAMPLE_W-1:0]       left_s1;
	logic [cdg_pkg::SAMPLE_W-1:0]       below_s1;
	logic                               first_s1;
	logic                               last_s1;
	logic                               drain_s1;
	logic                               end_s1;
	logic [cdg_pkg::SAMPLE_W-1:0]       prev_center_q;

	logic                               out_v_q;
	logic [cdg_pkg::OUT_DATA_W-1:0]     out_data_q;
	logic                               out_last_q;

	logic                               adv;
	logic [cdg_pkg::SAMPLE_W-1:0]       right;
	logic [cdg_pkg::SAMPLE_W-1:0]       above;
	logic [cdg_pkg::SAMPLE_W-1:0]       below;
	logic signed [cdg_pkg::DIFF_W-1:0]  gx;
	logic signed [cdg_pkg::DIFF_W-1:0]  gy;
	logic [cdg_pkg::BYTE_W-1:0]         red;
	logic [cdg_pkg::BYTE_W-1:0]         green;

	// Stage 1 moves on when the output register is free or being taken
	always_comb begin
		adv      = v_s1 && (!out_v_q || out_ready);
		in_ready = !v_s1 || !out_v_q || out_ready;
	end

	// Clamp neighbors at the frame edges and form the differences
	always_comb begin
		right = last_s1  ? center_s1 : mid_rdata;
		above = first_s1 ? center_s1 : upper_rdata;
		below = drain_s1 ? center_s1 : below_s1;
		gx    = $signed({1'b0, right}) - $signed({1'b0, left_s1});
		gy    = $signed({1'b0, below}) - $signed({1'b0, above});
		red   = gx[cdg_pkg::DIFF_W-1] ? '0 : gx[cdg_pkg::BYTE_W:1];
		green = gy[cdg_pkg::DIFF_W-1] ? '0 : gy[cdg_pkg::BYTE_W:1];
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Capture the center and its left neighbor; the fresh read is the right one
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			prev_center_q <= mid_rdata;
		end
		if (cmd.emit) begin
			center_s1 <= mid_rdata;
			left_s1   <= cmd.col_zero ? mid_rdata : prev_center_q;
			below_s1  <= sample;
			first_s1  <= cmd.first_row;
			last_s1   <= cmd.last_col;
			drain_s1  <= cmd.drain;
			end_s1    <= cmd.frame_end;
		end
		if (adv) begin
			out_data_q <= {green, red, gy, gx};
			out_last_q <= end_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// A full stage 1 behind a held output blocks new beats
	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_v_q && !out_ready) |-> !in_ready)
		else $error("beat accepted while pipeline is held");

	// An output beat only appears from stage 1
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s1))
		else $error("output valid without a stage 1 beat");

	// An empty output register never stalls the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> in_ready)
		else $error("input stalled with empty output");

endmodule
